// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nms assertion failed");

`define NMS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("nms assertion failed");

`else

`define NMS_ASSERT(lbl, clk, rst_n, prop)

`define NMS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ===== hdl/nms_pkg.sv =====
// ---------------------------------------------------------------------------
// nms_pkg
// shared types and constants of the box suppression filter
// ---------------------------------------------------------------------------
package nms_pkg;

  localparam int unsigned MAX_KEPT_DEF = 64;
  localparam logic [8:0]  THRESH_RESET = 9'd102;
  localparam int unsigned IOU_LAT      = 4;
  localparam logic [4:0]  ONE_PIXEL    = 5'd16;

  localparam logic [1:0] VERDICT_SUPPRESSED = 2'd0;
  localparam logic [1:0] VERDICT_STORED     = 2'd1;
  localparam logic [1:0] VERDICT_FULL       = 2'd2;

  typedef struct packed {
    logic               first_of_set;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic        [14:0] box_w;
    logic        [14:0] box_h;
  } box_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] box_number;
    logic [6:0]  kept_total;
  } box_out_t;

  // one held box with its area precomputed
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [14:0] w;
    logic        [14:0] h;
    logic        [29:0] area;
  } kept_box_t;

endpackage

// ===== hdl/nms_cell.sv =====
// ---------------------------------------------------------------------------
// nms_cell
// one slot of the rotating kept-box ring
// ---------------------------------------------------------------------------
module nms_cell
  import nms_pkg::*;
(
  input  logic      clk_i,
  input  logic      shift_i,
  input  logic      load_i,
  input  kept_box_t nbr_i,
  input  kept_box_t load_data_i,
  output kept_box_t box_o
);

  kept_box_t box_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      box_q <= load_data_i;
    end else if (shift_i) begin
      box_q <= nbr_i;
    end
  end

  assign box_o = box_q;

endmodule

// ===== hdl/nms_iou.sv =====
// ---------------------------------------------------------------------------
// nms_iou
// pipelined overlap test: inter*256 > threshold*union
// ---------------------------------------------------------------------------
module nms_iou
  import nms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  kept_box_t cur_i,
  input  kept_box_t held_i,
  input  logic [8:0] thresh_i,
  output logic      hit_o
);

  logic signed [18:0] ow_raw, oh_raw;
  logic signed [16:0] ea_x, eb_x, ea_y, eb_y, min_x, max_x, min_y, max_y;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [15:0] ow1_q, oh1_q;
  logic [30:0] asum1_q, asum2_q;
  logic [31:0] inter2_q;
  logic signed [33:0] uni3_q;
  logic signed [43:0] lhs3_q, lhs4_q, rhs4_q;

  always_comb begin
    ea_x  = 17'(cur_i.x) + $signed({2'b00, cur_i.w});
    eb_x  = 17'(held_i.x) + $signed({2'b00, held_i.w});
    ea_y  = 17'(cur_i.y) + $signed({2'b00, cur_i.h});
    eb_y  = 17'(held_i.y) + $signed({2'b00, held_i.h});
    min_x = (ea_x < eb_x) ? ea_x : eb_x;
    min_y = (ea_y < eb_y) ? ea_y : eb_y;
    max_x = (cur_i.x > held_i.x) ? 17'(cur_i.x) : 17'(held_i.x);
    max_y = (cur_i.y > held_i.y) ? 17'(cur_i.y) : 17'(held_i.y);
    ow_raw = 19'(min_x) - 19'(max_x) + $signed(19'(ONE_PIXEL));
    oh_raw = 19'(min_y) - 19'(max_y) + $signed(19'(ONE_PIXEL));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // overlap extents, clamped at zero; never exceed w+16 so 16 bits hold them
    ow1_q   <= ow_raw[18] ? 16'd0 : ow_raw[15:0];
    oh1_q   <= oh_raw[18] ? 16'd0 : oh_raw[15:0];
    asum1_q <= 31'(cur_i.area) + 31'(held_i.area);
    inter2_q <= ow1_q * oh1_q;
    asum2_q  <= asum1_q;
    uni3_q   <= $signed({3'b000, asum2_q}) - $signed({2'b00, inter2_q});
    lhs3_q   <= $signed({4'b0000, inter2_q, 8'h00});
    rhs4_q   <= 44'($signed({1'b0, thresh_i}) * uni3_q);
    lhs4_q   <= lhs3_q;
  end

  assign hit_o = v4_q && (lhs4_q > rhs4_q);

endmodule

// ===== hdl/greedy_nms_box_filter.sv =====
// ---------------------------------------------------------------------------
// greedy_nms_box_filter
// greedy non-maximum suppression over score-sorted boxes
// ---------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_data_i   (box_in_t)
// out      output     out_valid_o/out_stall_i out_data_o (box_out_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (overlap threshold)
//
// for each box the kept ring rotates once past the single overlap unit at
// its head, then the overlap pipeline drains and the verdict is written
// reset clears the count, box counter and handshake state and sets the
// threshold to THRESH_RESET; the ring contents are not reset, only slots
// below the count are looked at
// a pending result may sit stalled at the output while the next box is taken
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_nms_box_filter
  import nms_pkg::*;
#(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  box_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output box_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MAX_KEPT + 1);
  localparam int unsigned IdxW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned DrnW  = $clog2(IOU_LAT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q, count_next;
  logic [15:0]      counter_q, number_q;
  logic [IdxW-1:0]  step_q;
  logic [DrnW-1:0]  drain_q;
  logic             supp_q;
  logic [8:0]       thresh_q;
  kept_box_t        cur_q;
  logic             out_valid_q;
  box_out_t         out_q;

  logic             in_acc, shift, issue, hit, can_emit, emit, store;
  logic [1:0]       verdict;
  kept_box_t        ring [MAX_KEPT];

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign shift       = (state_q == ST_SCAN);
  // slot at the head holds original entry step_q during the scan
  assign issue       = shift && (CntW'(step_q) < count_q);
  assign can_emit    = !out_valid_q || !out_stall_i;
  // verdict goes to the output register in this cycle
  assign emit        = (state_q == ST_DONE) && can_emit;
  assign store       = emit && !supp_q && (count_q < CntW'(MAX_KEPT));

  always_comb begin
    if (supp_q) begin
      verdict = VERDICT_SUPPRESSED;
    end else if (count_q < CntW'(MAX_KEPT)) begin
      verdict = VERDICT_STORED;
    end else begin
      verdict = VERDICT_FULL;
    end
    count_next = store ? count_q + CntW'(1) : count_q;
  end

  // ring of cells rotating toward slot 0, one full turn per box
  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_ring
    nms_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (store && (count_q[IdxW-1:0] == IdxW'(g))),
      .nbr_i       (ring[(g + 1) % MAX_KEPT]),
      .load_data_i (cur_q),
      .box_o       (ring[g])
    );
  end

  nms_iou u_iou (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (issue),
    .cur_i    (cur_q),
    .held_i   (ring[0]),
    .thresh_i (thresh_q),
    .hit_o    (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      counter_q   <= '0;
      number_q    <= '0;
      step_q      <= '0;
      drain_q     <= '0;
      supp_q      <= 1'b0;
      thresh_q    <= THRESH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thresh_q <= cfg_data_i;
      end
      // output taken and no new verdict behind it
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            // first box of a set empties the store and restarts numbering
            if (in_data_i.first_of_set) begin
              count_q   <= '0;
              number_q  <= '0;
              counter_q <= 16'd1;
            end else begin
              number_q  <= counter_q;
              counter_q <= (counter_q == 16'hFFFF) ? counter_q : counter_q + 16'd1;
            end
            step_q  <= '0;
            supp_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) supp_q <= 1'b1;
          step_q <= step_q + IdxW'(1);
          if (step_q == IdxW'(MAX_KEPT - 1)) begin
            drain_q <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (hit) supp_q <= 1'b1;
          drain_q <= drain_q + DrnW'(1);
          if (drain_q == DrnW'(IOU_LAT - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_emit) begin
            count_q     <= count_next;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q.x    <= in_data_i.box_x;
      cur_q.y    <= in_data_i.box_y;
      cur_q.w    <= in_data_i.box_w;
      cur_q.h    <= in_data_i.box_h;
      cur_q.area <= in_data_i.box_w * in_data_i.box_h;
    end
    if (emit) begin
      out_q.verdict    <= verdict;
      out_q.box_number <= number_q;
      out_q.kept_total <= 7'(count_next);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NMS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MAX_KEPT))
  `NMS_ASSERT_NEXT(a_accept_scans, clk_i, rst_ni, in_acc, state_q == ST_SCAN)
  `NMS_ASSERT_NEXT(a_done_emits, clk_i, rst_ni, emit, out_valid_q && (state_q == ST_IDLE))
  `NMS_ASSERT_NEXT(a_no_hit_idle, clk_i, rst_ni, state_q == ST_IDLE, !hit)

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the greedy box suppression filter: boxes are sent
// through the stall handshake, each verdict is predicted in the bench and
// compared field by field against the filter's output in order
// ---------------------------------------------------------------------------
module testbench;
  import nms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEPT_DEPTH = MAX_KEPT_DEF;
  // length of one box's pass through the filter at the default depth
  localparam int unsigned BOX_CYCLES = KEPT_DEPTH + IOU_LAT + 2;
  localparam int unsigned DRAIN_CYCLES = 4 * BOX_CYCLES;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  box_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  box_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [8:0] cfg_data_i = '0;

  greedy_nms_box_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state: a copy of the kept store, count, counter and threshold
  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
  } held_t;

  held_t       kept_q[$];
  int unsigned set_pos;
  logic [8:0]  iou_thresh;

  box_out_t    verdict_q[$];
  int unsigned error_count;
  int unsigned box_count;
  int unsigned result_count;
  int unsigned idle_cycles;
  int unsigned full_count;
  int unsigned suppressed_count;

  // idling controls
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;

  // true if the incoming box overlaps a held box beyond the threshold
  function automatic bit too_much_overlap(held_t a, held_t b, logic [8:0] thr);
    longint ow;
    longint oh;
    longint inter;
    longint uni;
    ow = ((a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w)
       - ((a.x > b.x) ? a.x : b.x) + 16;
    oh = ((a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h)
       - ((a.y > b.y) ? a.y : b.y) + 16;
    if (ow < 0) ow = 0;
    if (oh < 0) oh = 0;
    inter = ow * oh;
    uni = a.w * a.h + b.w * b.h - inter;
    return inter * 256 > longint'(thr) * uni;
  endfunction

  // works out the verdict of one box and updates the predicted store
  function automatic box_out_t predict_verdict(box_in_t b);
    box_out_t r;
    held_t    cur;
    bit       keep;
    if (b.first_of_set) begin
      kept_q.delete();
      set_pos = 0;
    end
    cur.x = longint'(b.box_x);
    cur.y = longint'(b.box_y);
    cur.w = longint'({1'b0, b.box_w});
    cur.h = longint'({1'b0, b.box_h});
    r.box_number = set_pos[15:0];
    if (set_pos < 16'hFFFF) set_pos++;
    keep = 1'b1;
    foreach (kept_q[i]) begin
      if (too_much_overlap(cur, kept_q[i], iou_thresh)) keep = 1'b0;
    end
    if (!keep) begin
      r.verdict = VERDICT_SUPPRESSED;
    end else if (kept_q.size() < KEPT_DEPTH) begin
      kept_q.insert(kept_q.size(), cur);
      r.verdict = VERDICT_STORED;
    end else begin
      r.verdict = VERDICT_FULL;
    end
    r.kept_total = 7'(kept_q.size());
    return r;
  endfunction

  // sends one box, holding it until the filter takes it
  task automatic send_box(box_in_t b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    verdict_q.insert(verdict_q.size(), predict_verdict(b));
    box_count++;
    in_valid_i <= 1'b0;
    // the filter is busy with this box now, so this costs no throughput
    @(posedge clk_i);
  endtask

  // waits until every expected verdict has come, then lets the pipe settle
  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes the threshold register while the filter is idle
  task automatic write_thresh(logic [8:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    iou_thresh = v;
  endtask

  function automatic box_in_t make_box(bit first, int x, int y, int w, int h);
    box_in_t b;
    b.first_of_set = first;
    b.box_x = 16'(x);
    b.box_y = 16'(y);
    b.box_w = 15'(w);
    b.box_h = 15'(h);
    return b;
  endfunction

  // a box near a cluster center, so overlaps are common
  function automatic box_in_t cluster_box(bit first, int cx, int cy);
    return make_box(first, cx + $urandom_range(320) - 160, cy + $urandom_range(320) - 160,
                    $urandom_range(800, 16), $urandom_range(800, 16));
  endfunction

  function automatic box_in_t noise_box(bit first);
    box_in_t b;
    b = box_in_t'(63'({$urandom, $urandom}));
    b.first_of_set = first;
    return b;
  endfunction

  // checker: compare each verdict with the oldest expectation
  always @(posedge clk_i) begin
    box_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no box pending");
        error_count++;
      end else begin
        exp_r = verdict_q.pop_front();
        result_count++;
        if (exp_r.verdict == VERDICT_FULL) full_count++;
        if (exp_r.verdict == VERDICT_SUPPRESSED) suppressed_count++;
        if (out_data_o.verdict !== exp_r.verdict) begin
          $error("verdict: expected %0d actual %0d", exp_r.verdict, out_data_o.verdict);
          error_count++;
        end
        if (out_data_o.box_number !== exp_r.box_number) begin
          $error("box_number: expected %0d actual %0d",
                 exp_r.box_number, out_data_o.box_number);
          error_count++;
        end
        if (out_data_o.kept_total !== exp_r.kept_total) begin
          $error("kept_total: expected %0d actual %0d",
                 exp_r.kept_total, out_data_o.kept_total);
          error_count++;
        end
      end
    end
  end

  // receiver stall, random or held off for a long stretch
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // extremes of the fields, counter wrap-around is not reached here
  task automatic test_directed();
    send_box(make_box(1, 0, 0, 160, 160));
    send_box(make_box(0, 0, 0, 160, 160));           // identical, suppressed
    send_box(make_box(0, -32768, -32768, 0, 0));     // zero area, far corner
    send_box(make_box(0, 32767, 32767, 32767, 32767));
    send_box(make_box(0, -32768, 32767, 32767, 0));
    send_box(make_box(0, 32767, -32768, 0, 32767));
    send_box(make_box(0, 1000, 1000, 0, 0));         // zero area near nothing
    send_box(make_box(0, 1000, 1000, 0, 0));         // positive overlap, union < 0
    send_box(make_box(0, 5000, 5000, 16, 16));
    send_box(make_box(0, 5008, 5008, 16, 16));
    send_box(make_box(1, -100, -100, 32767, 32767)); // new set
    send_box(make_box(0, -100, -100, 32767, 32767));
    wait_drained();
    write_thresh(9'd256);
    send_box(make_box(1, 0, 0, 160, 160));
    send_box(make_box(0, 0, 0, 160, 160));           // identical, ratio above 1 at threshold 1.0
    send_box(make_box(0, 300, 300, 0, 0));
    send_box(make_box(0, 300, 300, 0, 0));
    wait_drained();
    write_thresh(9'h1FF);                            // above 256
    send_box(make_box(1, 0, 0, 160, 160));
    send_box(make_box(0, 0, 0, 160, 160));
    send_box(make_box(0, 50, 50, 0, 0));
    wait_drained();
    write_thresh(9'd0);
    send_box(make_box(1, 0, 0, 160, 160));
    send_box(make_box(0, 4000, 4000, 160, 160));
    send_box(make_box(0, 150, 150, 160, 160));
    wait_drained();
  endtask

  // fill the store past its depth with disjoint boxes
  task automatic test_store_full();
    write_thresh(THRESH_RESET);
    for (int i = 0; i < KEPT_DEPTH + 6; i++) begin
      send_box(make_box(i == 0, -32000 + (i % 9) * 7000, -32000 + (i / 9) * 4000, 320, 320));
    end
    wait_drained();
  endtask

  // random sets under one idling setting
  task automatic test_random_sets(int unsigned n, logic [8:0] thr);
    int cx;
    int cy;
    int unsigned k;
    write_thresh(thr);
    k = 0;
    while (k < n) begin
      int unsigned len;
      len = $urandom_range(40, 2);
      for (int j = 0; j < len && k < n; j++) begin
        if ($urandom_range(9) == 0) begin
          send_box(noise_box($urandom_range(19) == 0));
        end else begin
          if (j % 6 == 0) begin
            cx = int'($urandom_range(60000)) - 30000;
            cy = int'($urandom_range(60000)) - 30000;
          end
          send_box(cluster_box(j == 0, cx, cy));
        end
        k++;
      end
    end
    wait_drained();
  endtask

  // receiver holds off while boxes keep coming, so the sender stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) send_box(cluster_box(i == 0, 0, 0));
      end
    join
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    box_count = 0;
    result_count = 0;
    idle_cycles = 0;
    full_count = 0;
    suppressed_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    kept_q.delete();
    set_pos = 0;
    iou_thresh = THRESH_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_store_full();
    test_random_sets(300, 9'd102);
    send_idle_pct = 54;
    test_random_sets(300, 9'd180);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    test_random_sets(300, 9'd30);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    test_random_sets(300, 9'($urandom_range(256)));
    recv_stall_pct = 0;
    test_backpressure();
    send_idle_pct = 0;
    test_random_sets(100, 9'd256);

    wait_drained();
    $display("boxes sent %0d, verdicts checked %0d (%0d suppressed, %0d store full)",
             box_count, result_count, suppressed_count, full_count);
    $display("thresholds from 0 to 511, four idling mixes and one long output hold-off");
    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
